// File: src/fsft_pkg.sv
// ----------------------------------------------------------------------------
// fsft_pkg
// Shared types, constants and command encodings of the fan triangulator.
// ----------------------------------------------------------------------------
package fsft_pkg;

    // default coordinate width (Q7.8 at 16 bits)
    localparam int COORD_BITS_DEF = 16;

    // widths of the normal arithmetic
    localparam int MUL_W  = 32;
    localparam int WIDE_W = 64;
    localparam int NRM_W  = 16;
    localparam int STEP_W = 5;

    // one in Q1.14 and the near-zero bound on the squared cross length
    localparam logic [NRM_W-1:0] ONE_Q14      = 16'd16384;
    localparam logic [6:0]       NEAR_ZERO_SQ = 7'd43;

    // iteration counts of the sequenced units (last step index)
    localparam logic [STEP_W-1:0] CROSS_LAST  = 5'd6;
    localparam logic [STEP_W-1:0] SQUARE_LAST = 5'd3;
    localparam logic [STEP_W-1:0] SQRT_LAST   = 5'd30;
    localparam logic [STEP_W-1:0] DIV_LAST    = 5'd15;

    // lane codes for the three vector components / triangle corners
    localparam logic [1:0] LANE_0 = 2'd0;
    localparam logic [1:0] LANE_1 = 2'd1;
    localparam logic [1:0] LANE_2 = 2'd2;

    // vertex count codes
    localparam logic [1:0] CNT_NONE   = 2'd0;
    localparam logic [1:0] CNT_ANCHOR = 2'd1;
    localparam logic [1:0] CNT_TWO    = 2'd2;
    localparam logic [1:0] CNT_FULL   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIFF,
        ST_CROSS,
        ST_ABS,
        ST_DEGEN_CHK,
        ST_NORM,
        ST_SQUARE,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_STORE,
        ST_EMIT,
        ST_ADVANCE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_OPEN_FACE,
        OP_SECOND,
        OP_DIFF,
        OP_CROSS,
        OP_ABS,
        OP_DEGEN,
        OP_NORM,
        OP_SQUARE,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_DIV_LOAD,
        OP_DIV,
        OP_DIV_STORE,
        OP_ADVANCE
    } t_dp_op;

    typedef struct packed {
        t_dp_op            op;
        logic [STEP_W-1:0] step;
        logic [1:0]        lane;
    } t_dp_cmd;

    typedef struct packed {
        logic       sof;
        logic [1:0] count;
        logic       skip;
        logic       degenerate;
        logic       mag_high;
        logic       mag_low;
    } t_dp_status;

endpackage

// File: src/fsft_ifs.sv
// ----------------------------------------------------------------------------
// fsft channel interfaces
// Vertex input channel and triangle vertex output channel, valid/ready.
// ----------------------------------------------------------------------------
interface fsft_vtx_if #(
    parameter int COORD_BITS = fsft_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         start_of_face;
    logic                         face_hidden;

    modport source (
        output valid, pos_x, pos_y, pos_z, start_of_face, face_hidden,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, start_of_face, face_hidden,
        output ready
    );
endinterface

interface fsft_tri_if #(
    parameter int COORD_BITS = fsft_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic signed [15:0]           normal_x;
    logic signed [15:0]           normal_y;
    logic signed [15:0]           normal_z;
    logic                         last_of_triangle;

    modport source (
        output valid, out_x, out_y, out_z, normal_x, normal_y, normal_z,
        output last_of_triangle,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, normal_x, normal_y, normal_z,
        input  last_of_triangle,
        output ready
    );
endinterface

// File: src/fsft_ctrl.sv
// ----------------------------------------------------------------------------
// fsft_ctrl
// Sequencer of the triangulator: walks the face state, the normal unit
// steps and the three-item triangle emission.
// ----------------------------------------------------------------------------
module fsft_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  fsft_pkg::t_dp_status i_status,
    output fsft_pkg::t_dp_cmd    o_cmd
);

    fsft_pkg::t_state                r_state, n_state;
    logic [fsft_pkg::STEP_W-1:0]     r_step,  n_step;
    logic [1:0]                      r_lane,  n_lane;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsft_pkg::ST_IDLE;
            r_step  <= '0;
            r_lane  <= fsft_pkg::LANE_0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_lane  <= n_lane;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_lane  = r_lane;
        unique case (r_state)
            fsft_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = fsft_pkg::ST_DECIDE;
            end
            fsft_pkg::ST_DECIDE: begin
                if (i_status.sof) begin
                    n_state = fsft_pkg::ST_IDLE;
                end else begin
                    unique case (i_status.count)
                        fsft_pkg::CNT_NONE:   n_state = fsft_pkg::ST_IDLE;
                        fsft_pkg::CNT_ANCHOR: n_state = fsft_pkg::ST_IDLE;
                        fsft_pkg::CNT_TWO:    n_state = fsft_pkg::ST_DIFF;
                        default: begin
                            n_state = i_status.skip ? fsft_pkg::ST_ADVANCE
                                                    : fsft_pkg::ST_EMIT;
                            n_lane  = fsft_pkg::LANE_0;
                        end
                    endcase
                end
            end
            fsft_pkg::ST_DIFF: begin
                n_state = fsft_pkg::ST_CROSS;
                n_step  = '0;
            end
            fsft_pkg::ST_CROSS: begin
                if (r_step == fsft_pkg::CROSS_LAST) n_state = fsft_pkg::ST_ABS;
                else n_step = r_step + 1'b1;
            end
            fsft_pkg::ST_ABS: n_state = fsft_pkg::ST_DEGEN_CHK;
            fsft_pkg::ST_DEGEN_CHK: begin
                if (i_status.degenerate) begin
                    n_state = i_status.skip ? fsft_pkg::ST_ADVANCE : fsft_pkg::ST_EMIT;
                    n_lane  = fsft_pkg::LANE_0;
                end else begin
                    n_state = fsft_pkg::ST_NORM;
                end
            end
            fsft_pkg::ST_NORM: begin
                if (!i_status.mag_high && !i_status.mag_low) begin
                    n_state = fsft_pkg::ST_SQUARE;
                    n_step  = '0;
                end
            end
            fsft_pkg::ST_SQUARE: begin
                if (r_step == fsft_pkg::SQUARE_LAST) n_state = fsft_pkg::ST_SQRT_INIT;
                else n_step = r_step + 1'b1;
            end
            fsft_pkg::ST_SQRT_INIT: begin
                n_state = fsft_pkg::ST_SQRT;
                n_step  = '0;
            end
            fsft_pkg::ST_SQRT: begin
                if (r_step == fsft_pkg::SQRT_LAST) begin
                    n_state = fsft_pkg::ST_DIV_LOAD;
                    n_lane  = fsft_pkg::LANE_0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            fsft_pkg::ST_DIV_LOAD: begin
                n_state = fsft_pkg::ST_DIV;
                n_step  = '0;
            end
            fsft_pkg::ST_DIV: begin
                if (r_step == fsft_pkg::DIV_LAST) n_state = fsft_pkg::ST_DIV_STORE;
                else n_step = r_step + 1'b1;
            end
            fsft_pkg::ST_DIV_STORE: begin
                if (r_lane == fsft_pkg::LANE_2) begin
                    n_state = i_status.skip ? fsft_pkg::ST_ADVANCE : fsft_pkg::ST_EMIT;
                    n_lane  = fsft_pkg::LANE_0;
                end else begin
                    n_state = fsft_pkg::ST_DIV_LOAD;
                    n_lane  = r_lane + 1'b1;
                end
            end
            fsft_pkg::ST_EMIT: begin
                if (i_out_ready) begin
                    if (r_lane == fsft_pkg::LANE_2) n_state = fsft_pkg::ST_ADVANCE;
                    else n_lane = r_lane + 1'b1;
                end
            end
            fsft_pkg::ST_ADVANCE: n_state = fsft_pkg::ST_IDLE;
            default: n_state = fsft_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.op    = fsft_pkg::OP_NONE;
        o_cmd.step  = r_step;
        o_cmd.lane  = r_lane;
        unique case (r_state)
            fsft_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = fsft_pkg::OP_LOAD;
            end
            fsft_pkg::ST_DECIDE: begin
                if (i_status.sof) o_cmd.op = fsft_pkg::OP_OPEN_FACE;
                else if (i_status.count == fsft_pkg::CNT_ANCHOR)
                    o_cmd.op = fsft_pkg::OP_SECOND;
            end
            fsft_pkg::ST_DIFF:      o_cmd.op = fsft_pkg::OP_DIFF;
            fsft_pkg::ST_CROSS:     o_cmd.op = fsft_pkg::OP_CROSS;
            fsft_pkg::ST_ABS:       o_cmd.op = fsft_pkg::OP_ABS;
            fsft_pkg::ST_DEGEN_CHK: begin
                if (i_status.degenerate) o_cmd.op = fsft_pkg::OP_DEGEN;
            end
            fsft_pkg::ST_NORM:      o_cmd.op = fsft_pkg::OP_NORM;
            fsft_pkg::ST_SQUARE:    o_cmd.op = fsft_pkg::OP_SQUARE;
            fsft_pkg::ST_SQRT_INIT: o_cmd.op = fsft_pkg::OP_SQRT_INIT;
            fsft_pkg::ST_SQRT:      o_cmd.op = fsft_pkg::OP_SQRT;
            fsft_pkg::ST_DIV_LOAD:  o_cmd.op = fsft_pkg::OP_DIV_LOAD;
            fsft_pkg::ST_DIV:       o_cmd.op = fsft_pkg::OP_DIV;
            fsft_pkg::ST_DIV_STORE: o_cmd.op = fsft_pkg::OP_DIV_STORE;
            fsft_pkg::ST_EMIT:      o_out_valid = 1'b1;
            fsft_pkg::ST_ADVANCE:   o_cmd.op = fsft_pkg::OP_ADVANCE;
            default:                o_cmd.op = fsft_pkg::OP_NONE;
        endcase
    end

`ifndef NO_ASSERTIONS
    // the division lane index never leaves the three components
    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lane != 2'd3)
        else $error("lane index out of range");

    // a face that reaches emission has a normal and is not hidden
    a_emit_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !i_status.skip && !i_status.sof)
        else $error("emission for a hidden or unopened face");

    // the normal unit starts only on the third vertex of a face
    a_diff_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsft_pkg::ST_DIFF) |-> i_status.count == fsft_pkg::CNT_TWO)
        else $error("normal computed outside the third vertex");
`endif

endmodule

// File: src/fsft_dp.sv
// ----------------------------------------------------------------------------
// fsft_dp
// Datapath: face vertex registers, cross product over a shared multiplier,
// magnitude normalization, bitwise square root and restoring division.
// ----------------------------------------------------------------------------
module fsft_dp #(
    parameter int COORD_BITS = fsft_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fsft_pkg::t_dp_cmd            i_cmd,
    output fsft_pkg::t_dp_status         o_status,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic                         i_start_of_face,
    input  logic                         i_face_hidden,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic signed [COORD_BITS-1:0] o_out_z,
    output logic signed [15:0]           o_normal_x,
    output logic signed [15:0]           o_normal_y,
    output logic signed [15:0]           o_normal_z,
    output logic                         o_last_of_triangle
);

    localparam int DSHIFT = (COORD_BITS > 29) ? COORD_BITS - 29 : 0;
    localparam int MW = fsft_pkg::MUL_W;
    localparam int WW = fsft_pkg::WIDE_W;
    localparam int NW = fsft_pkg::NRM_W;

    // magnitude of a - b, shifted down for wide coordinates, sign restored
    function automatic logic signed [MW-1:0] scaled_diff(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        logic signed [WW-1:0] d;
        logic        [WW-1:0] m;
        logic signed [WW-1:0] r;
        d = WW'(p) - WW'(q);
        m = (d < 0) ? WW'(-d) : WW'(d);
        m = m >> DSHIFT;
        r = (d < 0) ? -$signed(m) : $signed(m);
        return r[MW-1:0];
    endfunction

    // face state
    logic signed [COORD_BITS-1:0] r_in [3];
    logic                         r_in_sof, r_in_hid;
    logic signed [COORD_BITS-1:0] r_anchor [3];
    logic signed [COORD_BITS-1:0] r_prev [3];
    logic [1:0]                   r_count;
    logic                         r_skip;
    logic signed [NW-1:0]         r_normal [3];

    // normal unit
    logic signed [MW-1:0] r_a [3];
    logic signed [MW-1:0] r_b [3];
    logic signed [WW-1:0] r_prod;
    logic signed [WW-1:0] r_c [3];
    logic        [WW-1:0] r_m [3];
    logic        [WW-1:0] r_sum;
    logic        [WW-1:0] r_x, r_root, r_bit;
    logic        [MW:0]   r_rem;
    logic        [NW-1:0] r_nlo, r_quo;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [WW-1:0] mul_p;
    logic        [2:0]    acc_step;
    logic        [WW-1:0] sqrt_t;
    logic        [MW+1:0] div_t;
    logic        [MW+1:0] div_len;
    logic        [WW-1:0] div_num;
    logic        [WW-1:0] m_lane;
    logic signed [WW-1:0] c_lane;
    logic        [NW-1:0] q_cap;
    logic        [7:0]    small_sq;

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.op == fsft_pkg::OP_CROSS) begin
            case (i_cmd.step[2:0])
                3'd0: begin mul_a = r_a[1]; mul_b = r_b[2]; end
                3'd1: begin mul_a = r_a[2]; mul_b = r_b[1]; end
                3'd2: begin mul_a = r_a[2]; mul_b = r_b[0]; end
                3'd3: begin mul_a = r_a[0]; mul_b = r_b[2]; end
                3'd4: begin mul_a = r_a[0]; mul_b = r_b[1]; end
                3'd5: begin mul_a = r_a[1]; mul_b = r_b[0]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (i_cmd.op == fsft_pkg::OP_SQUARE) begin
            case (i_cmd.step[1:0])
                2'd0: begin mul_a = $signed(r_m[0][MW-1:0]); mul_b = $signed(r_m[0][MW-1:0]); end
                2'd1: begin mul_a = $signed(r_m[1][MW-1:0]); mul_b = $signed(r_m[1][MW-1:0]); end
                2'd2: begin mul_a = $signed(r_m[2][MW-1:0]); mul_b = $signed(r_m[2][MW-1:0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end
    assign mul_p    = mul_a * mul_b;
    assign acc_step = i_cmd.step[2:0] - 3'd1;

    // per-lane selections for the divider
    always_comb begin
        case (i_cmd.lane)
            fsft_pkg::LANE_0: begin m_lane = r_m[0]; c_lane = r_c[0]; end
            fsft_pkg::LANE_1: begin m_lane = r_m[1]; c_lane = r_c[1]; end
            default:          begin m_lane = r_m[2]; c_lane = r_c[2]; end
        endcase
    end

    assign sqrt_t  = r_root + r_bit;
    assign div_len = (MW+2)'(r_root);
    assign div_t   = {r_rem, r_nlo[NW-1]};
    assign div_num = (m_lane << 14) + (r_root >> 1);
    assign q_cap   = (r_quo > fsft_pkg::ONE_Q14) ? fsft_pkg::ONE_Q14 : r_quo;

    // near-zero test: sum of squares below the bound implies all magnitudes small
    assign small_sq = 8'(r_m[0][2:0] * r_m[0][2:0]) + 8'(r_m[1][2:0] * r_m[1][2:0])
                    + 8'(r_m[2][2:0] * r_m[2][2:0]);

    always_comb begin
        o_status.sof        = r_in_sof;
        o_status.count      = r_count;
        o_status.skip       = r_skip;
        o_status.degenerate = (r_m[0][WW-1:3] == '0) && (r_m[1][WW-1:3] == '0)
                           && (r_m[2][WW-1:3] == '0)
                           && (small_sq < 8'(fsft_pkg::NEAR_ZERO_SQ));
        o_status.mag_high   = (|r_m[0][WW-1:30]) || (|r_m[1][WW-1:30]) || (|r_m[2][WW-1:30]);
        o_status.mag_low    = !o_status.mag_high && (r_m[0][WW-1:29] == '0)
                           && (r_m[1][WW-1:29] == '0) && (r_m[2][WW-1:29] == '0);
    end

    // face control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= fsft_pkg::CNT_NONE;
            r_skip  <= 1'b0;
        end else begin
            case (i_cmd.op)
                fsft_pkg::OP_OPEN_FACE: begin
                    r_count <= fsft_pkg::CNT_ANCHOR;
                    r_skip  <= r_in_hid;
                end
                fsft_pkg::OP_SECOND:  r_count <= fsft_pkg::CNT_TWO;
                fsft_pkg::OP_ADVANCE: r_count <= fsft_pkg::CNT_FULL;
                default: ;
            endcase
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_anchor[i] <= '0;
                r_prev[i]   <= '0;
                r_normal[i] <= '0;
            end
            r_in_sof <= 1'b0;
        end else begin
            case (i_cmd.op)
                fsft_pkg::OP_LOAD: begin
                    r_in[0]  <= i_pos_x;
                    r_in[1]  <= i_pos_y;
                    r_in[2]  <= i_pos_z;
                    r_in_sof <= i_start_of_face;
                    r_in_hid <= i_face_hidden;
                end
                fsft_pkg::OP_OPEN_FACE: begin
                    for (int i = 0; i < 3; i++) r_anchor[i] <= r_in[i];
                end
                fsft_pkg::OP_SECOND, fsft_pkg::OP_ADVANCE: begin
                    for (int i = 0; i < 3; i++) r_prev[i] <= r_in[i];
                end
                fsft_pkg::OP_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_a[i] <= scaled_diff(r_prev[i], r_anchor[i]);
                        r_b[i] <= scaled_diff(r_in[i], r_anchor[i]);
                    end
                end
                fsft_pkg::OP_CROSS: begin
                    r_prod <= mul_p;
                    // fold the previous product into its component
                    if (i_cmd.step != '0) begin
                        case (acc_step[2:1])
                            2'd0: r_c[0] <= acc_step[0] ? r_c[0] - r_prod : r_prod;
                            2'd1: r_c[1] <= acc_step[0] ? r_c[1] - r_prod : r_prod;
                            default: r_c[2] <= acc_step[0] ? r_c[2] - r_prod : r_prod;
                        endcase
                    end
                end
                fsft_pkg::OP_ABS: begin
                    for (int i = 0; i < 3; i++)
                        r_m[i] <= (r_c[i] < 0) ? WW'(-r_c[i]) : WW'(r_c[i]);
                end
                fsft_pkg::OP_DEGEN: begin
                    r_normal[0] <= '0;
                    r_normal[1] <= $signed(fsft_pkg::ONE_Q14);
                    r_normal[2] <= '0;
                end
                fsft_pkg::OP_NORM: begin
                    if (o_status.mag_high) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (o_status.mag_low) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end
                end
                fsft_pkg::OP_SQUARE: begin
                    r_prod <= mul_p;
                    if (i_cmd.step == '0) r_sum <= '0;
                    else r_sum <= r_sum + WW'(r_prod);
                end
                fsft_pkg::OP_SQRT_INIT: begin
                    r_x    <= r_sum;
                    r_root <= '0;
                    r_bit  <= WW'(1) << 60;
                end
                fsft_pkg::OP_SQRT: begin
                    if (r_x >= sqrt_t) begin
                        r_x    <= r_x - sqrt_t;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                fsft_pkg::OP_DIV_LOAD: begin
                    r_rem <= (MW+1)'(div_num >> NW);
                    r_nlo <= div_num[NW-1:0];
                    r_quo <= '0;
                end
                fsft_pkg::OP_DIV: begin
                    if (div_t >= div_len) begin
                        r_rem <= (MW+1)'(div_t - div_len);
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= (MW+1)'(div_t);
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                    r_nlo <= r_nlo << 1;
                end
                fsft_pkg::OP_DIV_STORE: begin
                    case (i_cmd.lane)
                        fsft_pkg::LANE_0: r_normal[0] <= (c_lane < 0) ? -$signed(q_cap) : $signed(q_cap);
                        fsft_pkg::LANE_1: r_normal[1] <= (c_lane < 0) ? -$signed(q_cap) : $signed(q_cap);
                        default:          r_normal[2] <= (c_lane < 0) ? -$signed(q_cap) : $signed(q_cap);
                    endcase
                end
                default: ;
            endcase
        end
    end

    // triangle corner selection for emission
    always_comb begin
        case (i_cmd.lane)
            fsft_pkg::LANE_0: begin
                o_out_x = r_anchor[0]; o_out_y = r_anchor[1]; o_out_z = r_anchor[2];
            end
            fsft_pkg::LANE_1: begin
                o_out_x = r_prev[0]; o_out_y = r_prev[1]; o_out_z = r_prev[2];
            end
            default: begin
                o_out_x = r_in[0]; o_out_y = r_in[1]; o_out_z = r_in[2];
            end
        endcase
    end
    assign o_normal_x         = r_normal[0];
    assign o_normal_y         = r_normal[1];
    assign o_normal_z         = r_normal[2];
    assign o_last_of_triangle = (i_cmd.lane == fsft_pkg::LANE_2);

endmodule

// File: src/flat_shaded_fan_triangulator.sv
// ----------------------------------------------------------------------------
// flat_shaded_fan_triangulator
// Fan triangulation of polygon faces with a flat face normal per face.
// ----------------------------------------------------------------------------
// Takes one vertex at a time and handles it to completion before taking the
// next. A face-opening, second or orphan vertex passes only through accept
// and decode. A later vertex of a visible face goes through accept, decode,
// three output items and the vertex update, where output stalls can hold the
// items; on a hidden face the output items are skipped. The third vertex of a
// face also computes the normal on a shared multiplier with a bit-serial
// square root and divider: a degenerate face takes a fixed normal after the
// cross product and its check, otherwise the work is set by the 7-step cross
// product, the normalization shifts (one bit a cycle), the 31-step square
// root and three divisions, one per component. Hidden faces emit nothing.
// ----------------------------------------------------------------------------
module flat_shaded_fan_triangulator #(
    parameter int COORD_BITS = fsft_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsft_vtx_if.sink   i_vtx,
    fsft_tri_if.source o_tri
);

    fsft_pkg::t_dp_cmd    cmd;
    fsft_pkg::t_dp_status status;

    // sequencer
    fsft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_vtx.valid),
        .o_in_ready  (i_vtx.ready),
        .o_out_valid (o_tri.valid),
        .i_out_ready (o_tri.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic and vertex storage
    fsft_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_pos_x            (i_vtx.pos_x),
        .i_pos_y            (i_vtx.pos_y),
        .i_pos_z            (i_vtx.pos_z),
        .i_start_of_face    (i_vtx.start_of_face),
        .i_face_hidden      (i_vtx.face_hidden),
        .o_out_x            (o_tri.out_x),
        .o_out_y            (o_tri.out_y),
        .o_out_z            (o_tri.out_z),
        .o_normal_x         (o_tri.normal_x),
        .o_normal_y         (o_tri.normal_y),
        .o_normal_z         (o_tri.normal_z),
        .o_last_of_triangle (o_tri.last_of_triangle)
    );

`ifndef NO_ASSERTIONS
    // one vertex in flight: no intake while a triangle is being sent
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_vtx.ready && o_tri.valid))
        else $error("input taken during emission");

    // an accepted vertex closes the intake on the next cycle
    a_intake_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vtx.valid && i_vtx.ready) |=> !i_vtx.ready)
        else $error("second vertex taken back to back");

    // a triangle ends on its last corner
    a_tri_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tri.valid && o_tri.ready && o_tri.last_of_triangle) |=> !o_tri.valid)
        else $error("emission continued past the last corner");

    // normal components stay within unit range
    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tri.valid |-> (o_tri.normal_x <= 16'sd16384) && (o_tri.normal_x >= -16'sd16384)
            && (o_tri.normal_y <= 16'sd16384) && (o_tri.normal_y >= -16'sd16384)
            && (o_tri.normal_z <= 16'sd16384) && (o_tri.normal_z >= -16'sd16384))
        else $error("normal component out of range");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the fan triangulator: vertex faces go in, the
// predicted triangle vertices and face normals are queued and compared
// against every output item in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CB        = fsft_pkg::COORD_BITS_DEF;
    localparam int MAX_CYC   = 400000;
    localparam int DRAIN_CYC = 300;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        logic signed [15:0]   nx;
        logic signed [15:0]   ny;
        logic signed [15:0]   nz;
        logic                 last;
    } t_corner;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fsft_vtx_if #(.COORD_BITS(CB)) vtx ();
    fsft_tri_if #(.COORD_BITS(CB)) tri_ch ();

    flat_shaded_fan_triangulator #(.COORD_BITS(CB)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx.sink),
        .o_tri   (tri_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [CB-1:0] anc_x, anc_y, anc_z, prv_x, prv_y, prv_z;
    logic signed [15:0]   fn_x, fn_y, fn_z;
    logic [1:0]           vcount;
    logic                 hidden;

    t_corner corner_q[$];
    int      errors = 0;
    int      cycles = 0;
    int      n_vertices = 0;
    int      n_corners = 0;
    int      n_faces = 0;

    // random gap: mostly short, some long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // normalized cross product of the face's first edges
    task automatic face_normal_calc(input logic signed [CB-1:0] qx, qy, qz);
        longint          ax, ay, az, bx, by, bz;
        longint          c[3];
        longint unsigned m[3], mx, s, len, q;
        logic signed [15:0] nrm[3];
        ax = longint'(prv_x) - anc_x; ay = longint'(prv_y) - anc_y;
        az = longint'(prv_z) - anc_z;
        bx = longint'(qx) - anc_x; by = longint'(qy) - anc_y;
        bz = longint'(qz) - anc_z;
        c[0] = ay * bz - az * by;
        c[1] = az * bx - ax * bz;
        c[2] = ax * by - ay * bx;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx < 64'h8000_0000) begin
            s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            if (s < fsft_pkg::NEAR_ZERO_SQ) begin
                fn_x = 0; fn_y = fsft_pkg::ONE_Q14; fn_z = 0;
                return;
            end
        end
        while (mx >= 64'h4000_0000) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < 64'h2000_0000) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = sqrt_floor(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 14) + (len >> 1)) / len;
            if (q > fsft_pkg::ONE_Q14) q = fsft_pkg::ONE_Q14;
            nrm[i] = c[i] < 0 ? -16'(q) : 16'(q);
        end
        fn_x = nrm[0]; fn_y = nrm[1]; fn_z = nrm[2];
    endtask

    task automatic queue_corner(input logic signed [CB-1:0] x, y, z, input logic last);
        t_corner c;
        c = '{x: x, y: y, z: z, nx: fn_x, ny: fn_y, nz: fn_z, last: last};
        corner_q = {corner_q, c};
    endtask

    // predict the triangle items caused by one vertex
    task automatic predict_vertex(input logic signed [CB-1:0] x, y, z,
                                  input logic sof, hid);
        if (sof) begin
            anc_x = x; anc_y = y; anc_z = z;
            hidden = hid;
            vcount = fsft_pkg::CNT_ANCHOR;
            n_faces++;
            return;
        end
        case (vcount)
            fsft_pkg::CNT_NONE: return;
            fsft_pkg::CNT_ANCHOR: begin
                prv_x = x; prv_y = y; prv_z = z;
                vcount = fsft_pkg::CNT_TWO;
                return;
            end
            fsft_pkg::CNT_TWO: begin
                face_normal_calc(x, y, z);
                vcount = fsft_pkg::CNT_FULL;
            end
            default: ;
        endcase
        if (!hidden) begin
            queue_corner(anc_x, anc_y, anc_z, 1'b0);
            queue_corner(prv_x, prv_y, prv_z, 1'b0);
            queue_corner(x, y, z, 1'b1);
        end
        prv_x = x; prv_y = y; prv_z = z;
    endtask

    // send one vertex item and wait for its acceptance
    task automatic send_vertex(input logic signed [CB-1:0] x, y, z,
                               input logic sof, hid);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vtx.valid         <= 1'b1;
        vtx.pos_x         <= x;
        vtx.pos_y         <= y;
        vtx.pos_z         <= z;
        vtx.start_of_face <= sof;
        vtx.face_hidden   <= hid;
        @(posedge i_clk iff vtx.ready);
        predict_vertex(x, y, z, sof, hid);
        n_vertices++;
    endtask

    function automatic logic signed [CB-1:0] rand_coord(input int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($signed($urandom_range(0, 2047)) - 1024);
            default: return CB'($signed($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    task automatic send_face(input int nverts, input logic hid, input int mode);
        for (int i = 0; i < nverts; i++)
            send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                        i == 0, i == 0 ? hid : 1'($urandom));
    endtask

    // output side: random stall and checking of each item
    always @(posedge i_clk) begin
        t_corner exp_c;
        if (i_rst_n && tri_ch.valid && tri_ch.ready) begin
            n_corners++;
            if (corner_q.size() == 0) begin
                $display("%0t: unexpected item x=%0d y=%0d z=%0d", $time,
                         tri_ch.out_x, tri_ch.out_y, tri_ch.out_z);
                errors++;
            end else begin
                exp_c = corner_q.pop_front();
                if (tri_ch.out_x !== exp_c.x || tri_ch.out_y !== exp_c.y ||
                    tri_ch.out_z !== exp_c.z || tri_ch.normal_x !== exp_c.nx ||
                    tri_ch.normal_y !== exp_c.ny || tri_ch.normal_z !== exp_c.nz ||
                    tri_ch.last_of_triangle !== exp_c.last) begin
                    $display("%0t: mismatch expected %0d %0d %0d n %0d %0d %0d l %0b",
                             $time, exp_c.x, exp_c.y, exp_c.z, exp_c.nx, exp_c.ny,
                             exp_c.nz, exp_c.last);
                    $display("%0t:          actual %0d %0d %0d n %0d %0d %0d l %0b",
                             $time, tri_ch.out_x, tri_ch.out_y, tri_ch.out_z,
                             tri_ch.normal_x, tri_ch.normal_y, tri_ch.normal_z,
                             tri_ch.last_of_triangle);
                    errors++;
                end
            end
        end
    end

    int stall_left = 0;
    bit stall_on = 1'b1;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            tri_ch.ready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            tri_ch.ready <= 1'b0;
        end else begin
            tri_ch.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("flat_shaded_fan_triangulator verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        logic signed [CB-1:0] mx, mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        // vertex with no open face after reset
        send_vertex(16'sd100, 16'sd5, -16'sd7, 1'b0, 1'b0);
        // unit triangle in xy plane, then one more fan vertex
        send_vertex('0, '0, '0, 1'b1, 1'b0);
        send_vertex(16'sd256, '0, '0, 1'b0, 1'b1);
        send_vertex('0, 16'sd256, '0, 1'b0, 1'b0);
        send_vertex(-16'sd256, '0, '0, 1'b0, 1'b1);
        // degenerate: collinear and tiny
        send_vertex('0, '0, '0, 1'b1, 1'b0);
        send_vertex(16'sd1, 16'sd1, 16'sd1, 1'b0, 1'b0);
        send_vertex(16'sd2, 16'sd2, 16'sd2, 1'b0, 1'b0);
        send_vertex(mx, mx, mx, 1'b1, 1'b0);
        send_vertex(mx, mx, mx - 16'sd1, 1'b0, 1'b0);
        send_vertex(mx, mx - 16'sd1, mx, 1'b0, 1'b0);
        // extremes of the coordinate range
        send_vertex(mn, mn, mn, 1'b1, 1'b0);
        send_vertex(mx, mn, mx, 1'b0, 1'b0);
        send_vertex(mn, mx, mx, 1'b0, 1'b0);
        send_vertex(mx, mx, mn, 1'b0, 1'b0);
        // hidden face
        send_vertex('0, '0, '0, 1'b1, 1'b1);
        send_vertex(16'sd300, '0, 16'sd9, 1'b0, 1'b0);
        send_vertex('0, 16'sd300, '0, 1'b0, 1'b0);
        send_vertex(16'sd5, 16'sd5, 16'sd5, 1'b0, 1'b0);
        // short faces with fewer than three vertices
        send_vertex(16'sd1, 16'sd2, 16'sd3, 1'b1, 1'b0);
        send_vertex(16'sd4, 16'sd5, 16'sd6, 1'b1, 1'b0);
        send_vertex(16'sd7, 16'sd8, 16'sd9, 1'b0, 1'b0);
    endtask

    task automatic test_random_faces();
        int r;
        while (n_vertices < 310) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_face($urandom_range(3, 7), $urandom_range(0, 5) == 0,
                          $urandom_range(0, 2));
            else if (r < 85)
                send_face($urandom_range(1, 2), 1'($urandom), $urandom_range(0, 2));
            else
                send_vertex(rand_coord(0), rand_coord(0), rand_coord(0),
                            1'b0, 1'($urandom));
        end
    endtask

    task automatic test_back_to_back();
        stall_on = 1'b0;
        for (int i = 0; i < 4; i++) send_face(5, 1'b0, 1);
        stall_on = 1'b1;
    endtask

    initial begin
        int waited;
        vtx.valid <= 1'b0;
        vtx.pos_x <= '0; vtx.pos_y <= '0; vtx.pos_z <= '0;
        vtx.start_of_face <= 1'b0;
        vtx.face_hidden <= 1'b0;
        anc_x = 0; anc_y = 0; anc_z = 0; prv_x = 0; prv_y = 0; prv_z = 0;
        fn_x = 0; fn_y = 0; fn_z = 0; vcount = fsft_pkg::CNT_NONE; hidden = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_faces();
        test_back_to_back();
        vtx.valid <= 1'b0;

        // drain the output side
        waited = 0;
        while (corner_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("covered %0d vertices in %0d faces, %0d triangle items checked",
                 n_vertices, n_faces, n_corners);
        if (errors == 0 && corner_q.size() == 0)
            $display("flat_shaded_fan_triangulator verification clean");
        else
            $display("flat_shaded_fan_triangulator verification failed");
        $finish;
    end
endmodule
